/* design/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define RSMP_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define RSMP_NEVER(name, clk, rst_n, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) else $error(msg);

`endif

/* design/rsmp_pkg.sv */
// Package for the reservoir sampler: sizes, state codes, control structs.
`default_nettype none
package rsmp_pkg;

    localparam int MAX_SAMPLES = 16;
    localparam int KCAP        = (MAX_SAMPLES < 16) ? MAX_SAMPLES : 16;
    localparam int KW          = $clog2(KCAP + 1);
    localparam int AW          = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int DIV_STEPS   = 32;
    localparam int DCW         = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_DIV,
        ST_WRITE,
        ST_READ,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic write;
        logic rd_start;
        logic rd;
        logic idx_inc;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic fill;
        logic div_done;
        logic eos;
        logic last;
    } t_status;

    // Reservoir size in use: zero acts as one, clamp to capacity.
    function automatic logic [KW-1:0] active_size(input logic [4:0] cfg);
        logic [KW-1:0] k;
        if (cfg == 5'd0) begin
            k = KW'(1);
        end else if (32'(cfg) > 32'(KCAP)) begin
            k = KW'(KCAP);
        end else begin
            k = KW'(cfg);
        end
        return k;
    endfunction

endpackage
`default_nettype wire

/* design/reservoir_sampler.sv */
// Top level of the streaming reservoir sampler (Algorithm R).
// Item handling while the reservoir fills: accept, decide, write; once full,
//   accept, decide, the 32-step serial modulo by count+1, then write; no new item until done.
// Readout after an end-of-stream item, per slot: memory read, then registered
//   output held until taken; min(count, k) slots.
// Synchronous active-low reset clears the FSM and item count, sets size 1; no memory reset.
`default_nettype none
module reservoir_sampler (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // size register write channel
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [4:0]         i_cfg_sample_size,
    // input items
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic signed [31:0] i_item_value,
    input  wire logic [31:0]        i_random_word,
    input  wire logic               i_end_of_stream,
    // result items
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [31:0]      o_sample_value,
    output logic [3:0]              o_slot_index,
    output logic                    o_last_of_run
);
    import rsmp_pkg::*;

    t_cmd    cmd;
    t_status status;

    // sequencing: fill/replace decision, modulo iterations, readout walk
    rsmp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // item count, divider, slot store and output register
    rsmp_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_sample_size (i_cfg_sample_size),
        .i_item_value      (i_item_value),
        .i_random_word     (i_random_word),
        .i_end_of_stream   (i_end_of_stream),
        .o_sample_value    (o_sample_value),
        .o_slot_index      (o_slot_index),
        .o_last_of_run     (o_last_of_run),
        .i_cmd             (cmd),
        .o_status          (status)
    );

endmodule
`default_nettype wire

/* design/rsmp_ctrl.sv */
// Controller state machine for the reservoir sampler.
`default_nettype none
module rsmp_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    output logic                   o_valid,
    input  wire logic              i_ready,
    input  wire rsmp_pkg::t_status i_status,
    output rsmp_pkg::t_cmd         o_cmd
);
    import rsmp_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        o_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                n_state = i_status.fill ? ST_WRITE : ST_DIV;
            end
            ST_DIV: begin
                o_cmd.step = 1'b1;
                if (i_status.div_done) begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                o_cmd.write = 1'b1;
                if (i_status.eos) begin
                    o_cmd.rd_start = 1'b1;
                    n_state        = ST_READ;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = ST_OUT;
            end
            ST_OUT: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    if (i_status.last) begin
                        o_cmd.clear = 1'b1;
                        n_state     = ST_IDLE;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state       = ST_READ;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

/* design/rsmp_dp.sv */
// Datapath: size register, item count, serial modulo, reservoir memory, readout.
`default_nettype none
module rsmp_dp (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [4:0]        i_cfg_sample_size,
    input  wire logic signed [31:0] i_item_value,
    input  wire logic [31:0]       i_random_word,
    input  wire logic              i_end_of_stream,
    output logic signed [31:0]     o_sample_value,
    output logic [3:0]             o_slot_index,
    output logic                   o_last_of_run,
    input  wire rsmp_pkg::t_cmd    i_cmd,
    output rsmp_pkg::t_status      o_status
);
    import rsmp_pkg::*;

    logic [4:0]      r_cfg;
    logic [31:0]     r_count;
    logic [31:0]     r_val;
    logic [31:0]     r_rnd;
    logic            r_eos;
    logic [KW-1:0]   r_k;
    logic [32:0]     r_div;
    logic [32:0]     r_rem;
    logic [DCW-1:0]  r_div_cnt;
    logic [KW-1:0]   r_idx;
    logic [31:0]     r_rd_data;
    logic [31:0]     mem [MAX_SAMPLES];

    logic [33:0]     rem_sh;
    logic [33:0]     div_ext;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [KW-1:0]   n_out;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= 5'd1;
        end else if (i_cfg_valid) begin
            r_cfg <= i_cfg_sample_size;
        end
    end

    // restoring modulo step, one quotient bit per cycle
    assign rem_sh  = {r_rem, r_rnd[31]};
    assign div_ext = {1'b0, r_div};

    assign o_status.fill     = r_count < 32'(r_k);
    assign o_status.div_done = r_div_cnt == DCW'(DIV_STEPS - 1);
    assign o_status.eos      = r_eos;

    assign wr_en   = o_status.fill || (r_rem < 33'(r_k));
    assign wr_addr = o_status.fill ? AW'(r_count) : AW'(r_rem);

    // readout length: min(count, k)
    assign n_out         = (r_count < 32'(r_k)) ? KW'(r_count) : r_k;
    assign o_status.last = KW'(r_idx + KW'(1)) == n_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.write) begin
            if (r_count != 32'hFFFF_FFFF) begin
                r_count <= r_count + 32'd1;
            end
        end else if (i_cmd.clear) begin
            r_count <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_val     <= i_item_value;
            r_rnd     <= i_random_word;
            r_eos     <= i_end_of_stream;
            r_k       <= active_size(r_cfg);
            r_div     <= {1'b0, r_count} + 33'd1;
            r_rem     <= '0;
            r_div_cnt <= '0;
        end else if (i_cmd.step) begin
            r_rnd     <= {r_rnd[30:0], 1'b0};
            r_div_cnt <= r_div_cnt + DCW'(1);
            if (rem_sh >= div_ext) begin
                r_rem <= 33'(rem_sh - div_ext);
            end else begin
                r_rem <= rem_sh[32:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write && wr_en) begin
            mem[wr_addr] <= r_val;
        end
        if (i_cmd.rd) begin
            r_rd_data <= mem[AW'(r_idx)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_start) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + KW'(1);
        end
    end

    assign o_sample_value = r_rd_data;
    assign o_slot_index   = 4'(r_idx);
    assign o_last_of_run  = o_status.last;

endmodule
`default_nettype wire

/* design/rsmp_checker.sv */
// Port-level checker for the reservoir sampler, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module rsmp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_ready,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [31:0] o_sample_value,
    input wire logic [3:0]  o_slot_index,
    input wire logic        o_last_of_run
);
    `RSMP_NEVER(a_no_overlap, i_clk, i_rst_n, o_valid && o_ready, "input ready while emitting")
    `RSMP_ASSERT(a_busy_after_accept, i_clk, i_rst_n, i_valid && o_ready |=> !o_ready, "ready right after item")
    `RSMP_ASSERT(a_more_after_mid, i_clk, i_rst_n, o_valid && i_ready && !o_last_of_run |=> !o_ready, "readout ended early")
    `RSMP_ASSERT(a_idle_after_last, i_clk, i_rst_n, o_valid && i_ready && o_last_of_run |=> o_ready, "not idle after readout")
    `RSMP_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid && $stable(o_sample_value) && $stable(o_slot_index), "stalled result changed")
endmodule

bind reservoir_sampler rsmp_checker u_rsmp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_sample_value (o_sample_value),
    .o_slot_index   (o_slot_index),
    .o_last_of_run  (o_last_of_run)
);
`default_nettype wire
